// ----- src/rib_pkg.sv -----
package rib_pkg;

  localparam int SIDE_W     = 7;
  localparam int TRIG_W     = 16;
  localparam int PIX_W      = 6;
  localparam int ADDR_W     = 12;
  localparam int RGBA_W     = 32;
  localparam int IDX_W      = 12;
  localparam int COLOR_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ICON_WIDTH  = 2'd0,
    CFG_ICON_HEIGHT = 2'd1,
    CFG_COS_HEADING = 2'd2,
    CFG_SIN_HEADING = 2'd3
  } cfg_reg_e;

  localparam logic [SIDE_W-1:0] SIDE_RST = 7'd64;
  localparam logic [TRIG_W-1:0] COS_RST  = 16'd16384;
  localparam logic [TRIG_W-1:0] SIN_RST  = 16'd0;

  localparam logic [7:0] BG_R = 8'd34;
  localparam logic [7:0] BG_G = 8'd46;
  localparam logic [7:0] BG_B = 8'd52;

  function automatic logic [COLOR_W-1:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  localparam logic [COLOR_W-1:0] BG_565 = pack565(BG_R, BG_G, BG_B);

endpackage

// ----- src/rib_if.sv -----
interface rib_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [rib_pkg::ADDR_W-1:0]     texel_address;
  logic [rib_pkg::RGBA_W-1:0]     texel_rgba;
  logic [rib_pkg::PIX_W-1:0]      pixel_x;
  logic [rib_pkg::PIX_W-1:0]      pixel_y;

  modport source (output valid, opcode, texel_address, texel_rgba, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, opcode, texel_address, texel_rgba, pixel_x, pixel_y,
                output ready);
endinterface

interface rib_out_if;
  logic                           valid;
  logic                           ready;
  logic [rib_pkg::IDX_W-1:0]      out_index;
  logic [rib_pkg::COLOR_W-1:0]    out_color;

  modport source (output valid, out_index, out_color, input ready);
  modport sink (input valid, out_index, out_color, output ready);
endinterface

// ----- src/rib_ram.sv -----
module rib_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rotated_icon_alpha_blit.sv -----
// A render transaction's result leaves from the registered output stage; loads give no output.
// Throughput: one transaction per cycle when not stalled, loads and renders alike; the texel store
// is touched at most once per transaction in a single pipeline stage, so loads and renders keep order.
// Backpressure stalls only the filled stages; bubbles ahead of a stall are taken up.
// Reset clears the pipeline and sets the icon to 64 by 64 at zero heading.
// The texel store is not cleared by reset.
module rotated_icon_alpha_blit #(
  parameter int MAX_ICON_SIDE = 64,
  parameter int TEXEL_DEPTH   = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rib_in_if.sink                           in_ch,
  rib_out_if.source                        out_ch,
  input  logic                             cfg_we_i,
  input  logic [rib_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rib_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int SW     = rib_pkg::SIDE_W;
  localparam int TW     = rib_pkg::TRIG_W;
  localparam int AW     = $clog2(TEXEL_DEPTH);
  localparam int V_W    = 2 * SW;
  localparam int RW     = (AW > V_W) ? AW : V_W;
  localparam int K      = V_W + AW;
  localparam int M_W    = V_W + 2;
  localparam int PROD_W = K + V_W;
  localparam int QD_W   = V_W + AW + 1;
  localparam int DXW    = SW + 2;
  localparam int PRD_W  = DXW + TW;
  localparam int NXW    = PRD_W + 2;
  localparam int LDX_W  = AW + rib_pkg::ADDR_W;
  localparam int NS     = 9;

  localparam logic [63:0]   RECIP_L    = (64'd1 << K) / 64'(TEXEL_DEPTH);
  localparam logic [M_W-1:0] RECIP_C   = M_W'(RECIP_L);
  localparam logic [RW:0]   DEPTH_C    = (RW + 1)'(TEXEL_DEPTH);
  localparam logic [SW-1:0] MAX_SIDE_C = (MAX_ICON_SIDE > 127) ? 7'd127 : 7'(MAX_ICON_SIDE);

  typedef struct packed {
    logic                           render;
    logic                           ld_ok;
    logic [AW-1:0]                  ld_addr;
    logic [rib_pkg::RGBA_W-1:0]     rgba;
    logic [rib_pkg::IDX_W-1:0]      idx;
    logic                           outside;
  } carry_t;

  logic [SW-1:0]        w_q, h_q;
  logic signed [TW-1:0] cos_q, sin_q;
  logic [SW-1:0]        side_v;
  logic [SW-1:0]        side_c;

  logic [NS:1] vld_q, vld_d, free;

  carry_t cr_q [1:8];
  carry_t cr_in;
  carry_t cr2_c;

  logic signed [DXW-1:0]   dx_in, dy_in;
  logic signed [PRD_W-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [NXW-1:0]   nx_c, ny_c, w_half_c, h_half_c, w_full_c, h_full_c;
  logic                    outside_c;
  logic [SW-1:0]           sx_q, sy_q;
  logic [V_W-1:0]          v3_q, v4_q, v5_q;
  logic [PROD_W-1:0]       prod_c;
  logic [V_W-1:0]          quo_q;
  logic [QD_W-1:0]         qd_c;
  logic [V_W-1:0]          qd_q;
  logic [RW-1:0]           rem_c;
  logic [AW-1:0]           tex_addr_q;
  logic [LDX_W-1:0]        ld_ext;
  logic [rib_pkg::RGBA_W-1:0] tex_rdata;
  logic                    ram_we, ram_re;
  logic [15:0]             sum_c [3];
  logic [15:0]             sum_q [3];
  logic [7:0]              fg_c [3];
  logic [7:0]              bg_c [3];
  logic [7:0]              alpha_c;
  logic [rib_pkg::IDX_W-1:0]   out_index_q;
  logic [rib_pkg::COLOR_W-1:0] out_color_q;
  logic [rib_pkg::COLOR_W-1:0] color_c;

  always_comb begin
    side_v = cfg_data_i[SW-1:0];
    if (side_v == '0) begin
      side_c = 7'd1;
    end else if (side_v > MAX_SIDE_C) begin
      side_c = MAX_SIDE_C;
    end else begin
      side_c = side_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= rib_pkg::SIDE_RST;
      h_q   <= rib_pkg::SIDE_RST;
      cos_q <= rib_pkg::COS_RST;
      sin_q <= rib_pkg::SIN_RST;
    end else if (cfg_we_i) begin
      unique case (rib_pkg::cfg_reg_e'(cfg_index_i))
        rib_pkg::CFG_ICON_WIDTH:  w_q   <= side_c;
        rib_pkg::CFG_ICON_HEIGHT: h_q   <= side_c;
        rib_pkg::CFG_COS_HEADING: cos_q <= cfg_data_i[TW-1:0];
        rib_pkg::CFG_SIN_HEADING: sin_q <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // A stage may take a new transaction when it is empty or its content moves on.
  always_comb begin
    free[NS] = !vld_q[NS] || out_ch.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      free[k] = !vld_q[k] || free[k+1];
    end
    vld_d = vld_q;
    if (free[1]) begin
      vld_d[1] = in_ch.valid;
    end
    for (int k = 2; k <= NS; k++) begin
      if (free[k]) begin
        vld_d[k] = (k == 7) ? (vld_q[k-1] && cr_q[6].render) : vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ch.ready = free[1];

  always_comb begin
    dx_in  = $signed({2'b00, in_ch.pixel_x, 1'b0}) - $signed({2'b00, w_q});
    dy_in  = $signed({2'b00, in_ch.pixel_y, 1'b0}) - $signed({2'b00, h_q});
    ld_ext = LDX_W'(in_ch.texel_address);
    cr_in.render  = (in_ch.opcode == rib_pkg::OP_RENDER);
    cr_in.ld_ok   = (32'(in_ch.texel_address) < 32'(TEXEL_DEPTH));
    cr_in.ld_addr = ld_ext[AW-1:0];
    cr_in.rgba    = in_ch.texel_rgba;
    cr_in.idx     = (12'(h_q) - 12'd1 - 12'(in_ch.pixel_y)) * 12'(w_q)
                  + (12'(w_q) - 12'd1 - 12'(in_ch.pixel_x));
    cr_in.outside = 1'b0;
  end

  always_comb begin
    w_half_c  = $signed(NXW'({w_q, 14'd0}));
    h_half_c  = $signed(NXW'({h_q, 14'd0}));
    w_full_c  = $signed(NXW'({w_q, 15'd0}));
    h_full_c  = $signed(NXW'({h_q, 15'd0}));
    nx_c      = NXW'(pxc_q) - NXW'(pys_q) + w_half_c;
    ny_c      = NXW'(pxs_q) + NXW'(pyc_q) + h_half_c;
    outside_c = (nx_c < 0) || (nx_c >= w_full_c) || (ny_c < 0) || (ny_c >= h_full_c);
    cr2_c         = cr_q[1];
    cr2_c.outside = outside_c;
  end

  // Store index modulo the store depth: reciprocal estimate, then one correction.
  always_comb begin
    prod_c = PROD_W'(v3_q) * PROD_W'(RECIP_C);
    qd_c   = QD_W'(quo_q) * QD_W'(TEXEL_DEPTH);
    rem_c  = RW'(v5_q - qd_q);
    if ({1'b0, rem_c} >= DEPTH_C) begin
      rem_c = rem_c - DEPTH_C[RW-1:0];
    end
  end

  always_comb begin
    alpha_c = tex_rdata[7:0];
    fg_c[0] = tex_rdata[31:24];
    fg_c[1] = tex_rdata[23:16];
    fg_c[2] = tex_rdata[15:8];
    bg_c[0] = rib_pkg::BG_R;
    bg_c[1] = rib_pkg::BG_G;
    bg_c[2] = rib_pkg::BG_B;
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = 16'(fg_c[c]) * 16'(alpha_c) + 16'(bg_c[c]) * 16'(8'd255 - alpha_c);
    end
    if (cr_q[8].outside) begin
      color_c = rib_pkg::BG_565;
    end else begin
      color_c = rib_pkg::pack565(rib_pkg::div255(sum_q[0]), rib_pkg::div255(sum_q[1]),
                                 rib_pkg::div255(sum_q[2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (free[1]) begin
      cr_q[1] <= cr_in;
      pxc_q   <= PRD_W'(dx_in) * PRD_W'(cos_q);
      pys_q   <= PRD_W'(dy_in) * PRD_W'(sin_q);
      pxs_q   <= PRD_W'(dx_in) * PRD_W'(sin_q);
      pyc_q   <= PRD_W'(dy_in) * PRD_W'(cos_q);
    end
    if (free[2]) begin
      cr_q[2] <= cr2_c;
      sx_q    <= nx_c[15 +: SW];
      sy_q    <= ny_c[15 +: SW];
    end
    if (free[3]) begin
      cr_q[3] <= cr_q[2];
      v3_q    <= V_W'(sy_q) * V_W'(w_q) + V_W'(sx_q);
    end
    if (free[4]) begin
      cr_q[4] <= cr_q[3];
      quo_q   <= prod_c[K +: V_W];
      v4_q    <= v3_q;
    end
    if (free[5]) begin
      cr_q[5] <= cr_q[4];
      qd_q    <= V_W'(qd_c);
      v5_q    <= v4_q;
    end
    if (free[6]) begin
      cr_q[6]    <= cr_q[5];
      tex_addr_q <= rem_c[AW-1:0];
    end
    if (free[7]) begin
      cr_q[7] <= cr_q[6];
    end
    if (free[8]) begin
      cr_q[8] <= cr_q[7];
      sum_q   <= sum_c;
    end
    if (free[9]) begin
      out_index_q <= cr_q[8].idx;
      out_color_q <= color_c;
    end
  end

  assign ram_we = free[7] && vld_q[6] && !cr_q[6].render && cr_q[6].ld_ok;
  assign ram_re = free[7] && vld_q[6] && cr_q[6].render;

  rib_ram #(
    .WIDTH (rib_pkg::RGBA_W),
    .DEPTH (TEXEL_DEPTH)
  ) u_texels (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cr_q[6].ld_addr),
    .wdata_i (cr_q[6].rgba),
    .re_i    (ram_re),
    .raddr_i (tex_addr_q),
    .rdata_o (tex_rdata)
  );

  assign out_ch.valid     = vld_q[NS];
  assign out_ch.out_index = out_index_q;
  assign out_ch.out_color = out_color_q;

endmodule

// ----- src/rib_checker.sv -----
module rib_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           in_opcode_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [rib_pkg::IDX_W-1:0]      out_index_i,
  input logic [rib_pkg::COLOR_W-1:0]    out_color_i
);

  logic [3:0] pend_q;
  logic       in_render, out_acc;

  assign in_render = in_valid_i && in_ready_i && (in_opcode_i == rib_pkg::OP_RENDER);
  assign out_acc   = out_valid_i && out_ready_i;

  // Renders accepted whose result has not yet been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_render) - 4'(out_acc);
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_index_i) && $stable(out_color_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 4'd0)
    else $error("result without a pending render");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd9)
    else $error("more renders in flight than pipeline stages");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while the output is empty");

endmodule

bind rotated_icon_alpha_blit rib_checker u_rib_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_opcode_i (in_ch.opcode),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_index_i (out_ch.out_index),
  .out_color_i (out_ch.out_color)
);
